>>> rtl/fir_filter_circular_unit_defines.svh
// ----------------------------------------------------------------------------
// fir_filter_circular_unit_defines
// Assertion macros used by the checker of the FIR block.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_CIRCULAR_UNIT_DEFINES_SVH
`define FIR_FILTER_CIRCULAR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define FCU_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fcu checker: same-cycle property failed");

// next-cycle implication, sampled on clk, off while in reset
`define FCU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fcu checker: next-cycle property failed");

`endif

>>> rtl/fcu_pkg.sv
// ----------------------------------------------------------------------------
// fcu_pkg
// Types and constants of the circular-buffer FIR filter.
// ----------------------------------------------------------------------------
package fcu_pkg;

	localparam int TAPS   = 128;
	localparam int ADDR_W = $clog2(TAPS);
	localparam int SMP_W  = 16;
	localparam int TIDX_W = 7;
	localparam int PROD_W = 2 * SMP_W;
	localparam int ACC_W  = PROD_W + ADDR_W;
	localparam int FRAC   = SMP_W - 1;
	localparam int RND_W  = ACC_W + 1 - FRAC;

	typedef logic signed [SMP_W-1:0]  sample_t;
	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic [TIDX_W-1:0]        tidx_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	localparam logic ACTION_FILTER = 1'b0;
	localparam logic ACTION_COEF   = 1'b1;

	localparam sample_t SAT_MAX = {1'b0, {(SMP_W-1){1'b1}}};
	localparam sample_t SAT_MIN = {1'b1, {(SMP_W-1){1'b0}}};

	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} mac_ctrl_t;

endpackage

>>> rtl/fcu_req_if.sv
// ----------------------------------------------------------------------------
// fcu_req_if
// Input channel of the FIR filter: sample or coefficient items.
// ----------------------------------------------------------------------------
interface fcu_req_if;
	import fcu_pkg::*;

	logic    valid;
	logic    ready;
	logic    action;
	sample_t sample;
	tidx_t   tap_index;
	sample_t coefficient;

	modport source (output valid, output action, output sample, output tap_index,
		output coefficient, input ready);
	modport sink (input valid, input action, input sample, input tap_index,
		input coefficient, output ready);

endinterface

>>> rtl/fcu_res_if.sv
// ----------------------------------------------------------------------------
// fcu_res_if
// Output channel of the FIR filter: one filtered item per sample.
// ----------------------------------------------------------------------------
interface fcu_res_if;
	import fcu_pkg::*;

	logic    valid;
	logic    ready;
	sample_t filtered;
	logic    clipped;

	modport source (output valid, output filtered, output clipped, input ready);
	modport sink (input valid, input filtered, input clipped, output ready);

endinterface

>>> rtl/fcu_mac.sv
// ----------------------------------------------------------------------------
// fcu_mac
// Registered multiply, wide accumulate, round half up and saturate to Q1.15.
// ----------------------------------------------------------------------------
module fcu_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  fcu_pkg::mac_ctrl_t ctrl_s1,
	input  fcu_pkg::sample_t  x_s1,
	input  fcu_pkg::sample_t  c_s1,
	output logic              done,
	output fcu_pkg::sample_t  filtered,
	output logic              clipped
);
	import fcu_pkg::*;

	mac_ctrl_t               ctrl_s2;
	prod_t                   prod_s2;
	acc_t                    acc_q;
	logic                    done_q;
	logic signed [ACC_W:0]   biased;
	logic signed [RND_W-1:0] rounded;
	logic [RND_W-SMP_W:0]    hi_bits;
	logic                    in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
			done_q  <= 1'b0;
		end else begin
			ctrl_s2 <= ctrl_s1;
			done_q  <= ctrl_s2.vld && ctrl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= x_s1 * c_s1;
		if (ctrl_s2.vld) begin
			acc_q <= (ctrl_s2.first ? acc_t'(0) : acc_q) + ACC_W'(prod_s2);
		end
	end

	// add half an LSB, then floor by an arithmetic shift
	always_comb begin
		biased   = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(1 << (FRAC - 1));
		rounded  = biased[ACC_W:FRAC];
		hi_bits  = rounded[RND_W-1:SMP_W-1];
		in_range = (&hi_bits) || !(|hi_bits);
	end

	assign done     = done_q;
	assign clipped  = !in_range;
	assign filtered = in_range ? rounded[SMP_W-1:0]
		: (rounded[RND_W-1] ? SAT_MIN : SAT_MAX);

endmodule

>>> rtl/fir_filter_circular_unit.sv
// ----------------------------------------------------------------------------
// fir_filter_circular_unit: direct-form FIR over a circular delay line.
// Sample item: taken in idle, then the taps run, the MAC drains and the result is pushed;
// no new item is taken before that (one MAC a tap, one read of each memory per cycle);
// a stalled result holds the input off. Coefficient item: written in idle, stays ready.
// Reset clears per-entry valid bits at once, so both stores read zero; no clear pass.
// ----------------------------------------------------------------------------
module fir_filter_circular_unit (
	input logic       clk,
	input logic       arst_n,
	fcu_req_if.sink   req,
	fcu_res_if.source res
);
	import fcu_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_PUSH  = 4'b1000
	} state_t;

	state_t          state_q;
	addr_t           newest_q;
	addr_t           pos_q;
	addr_t           k_q;
	logic [TAPS-1:0] dl_vld_q;
	logic [TAPS-1:0] cw_vld_q;

	sample_t dl_mem [TAPS];
	sample_t cw_mem [TAPS];

	sample_t   dl_rd_s1;
	sample_t   cw_rd_s1;
	logic      dl_ok_s1;
	logic      cw_ok_s1;
	mac_ctrl_t ctrl_s1;

	logic    res_vld_q;
	sample_t filt_q;
	logic    clip_q;

	logic    take;
	logic    smp_we;
	logic    cw_we;
	addr_t   cw_addr;
	logic    last_k;
	logic    out_free;
	logic    mac_done;
	sample_t mac_filt;
	logic    mac_clip;

	assign take     = req.valid && req.ready;
	assign smp_we   = take && (req.action == ACTION_FILTER);
	assign cw_we    = take && (req.action == ACTION_COEF) && (int'(req.tap_index) < TAPS);
	assign cw_addr  = ADDR_W'(req.tap_index);
	assign last_k   = (k_q == ADDR_W'(TAPS - 1));
	assign out_free = !res_vld_q || res.ready;
	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			newest_q <= ADDR_W'(TAPS - 1);
			pos_q    <= '0;
			k_q      <= '0;
			dl_vld_q <= '0;
			cw_vld_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (smp_we) begin
						dl_vld_q[newest_q] <= 1'b1;
						pos_q    <= newest_q;
						k_q      <= '0;
						newest_q <= (newest_q == '0) ? ADDR_W'(TAPS - 1) : newest_q - 1'b1;
						state_q  <= ST_RUN;
					end
					if (cw_we) begin
						cw_vld_q[cw_addr] <= 1'b1;
					end
				end
				ST_RUN: begin
					k_q   <= k_q + 1'b1;
					pos_q <= (pos_q == ADDR_W'(TAPS - 1)) ? '0 : pos_q + 1'b1;
					if (last_k) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (mac_done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// delay line: sample write in idle, one registered read per cycle
	always_ff @(posedge clk) begin
		if (smp_we) begin
			dl_mem[newest_q] <= req.sample;
		end
		dl_rd_s1 <= dl_mem[pos_q];
	end

	always_ff @(posedge clk) begin
		if (cw_we) begin
			cw_mem[cw_addr] <= req.coefficient;
		end
		cw_rd_s1 <= cw_mem[k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1  <= '0;
			dl_ok_s1 <= 1'b0;
			cw_ok_s1 <= 1'b0;
		end else begin
			ctrl_s1.vld   <= (state_q == ST_RUN);
			ctrl_s1.first <= (k_q == '0);
			ctrl_s1.last  <= last_k;
			dl_ok_s1      <= dl_vld_q[pos_q];
			cw_ok_s1      <= cw_vld_q[k_q];
		end
	end

	fcu_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl_s1  (ctrl_s1),
		.x_s1     (dl_ok_s1 ? dl_rd_s1 : sample_t'(0)),
		.c_s1     (cw_ok_s1 ? cw_rd_s1 : sample_t'(0)),
		.done     (mac_done),
		.filtered (mac_filt),
		.clipped  (mac_clip)
	);

	// output register: hold the item until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (state_q == ST_PUSH && out_free) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && out_free) begin
			filt_q <= mac_filt;
			clip_q <= mac_clip;
		end
	end

	assign res.valid    = res_vld_q;
	assign res.filtered = filt_q;
	assign res.clipped  = clip_q;

endmodule

>>> rtl/fcu_checker.sv
// ----------------------------------------------------------------------------
// fcu_checker
// Port-level checks of the FIR filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "fir_filter_circular_unit_defines.svh"

module fcu_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             req_action,
	input logic             res_valid,
	input logic             res_ready,
	input fcu_pkg::sample_t res_filtered,
	input logic             res_clipped
);
	import fcu_pkg::*;

	// a stalled result holds
	`FCU_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_filtered) && $stable(res_clipped))

	// a clipped item sits at a rail
	`FCU_ASSERT_SAME(a_clip_rail, res_valid && res_clipped, res_filtered == SAT_MAX || res_filtered == SAT_MIN)

	// a sample item keeps the block busy
	`FCU_ASSERT_NEXT(a_smp_busy, req_valid && req_ready && req_action == ACTION_FILTER, !req_ready)

	// a coefficient item leaves the block ready
	`FCU_ASSERT_NEXT(a_coef_ready, req_valid && req_ready && req_action == ACTION_COEF, req_ready)

endmodule

bind fir_filter_circular_unit fcu_checker u_fcu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_action   (req.action),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_filtered (res.filtered),
	.res_clipped  (res.clipped)
);
